/* rtl/core/scs_pkg.sv */
`default_nettype none

package scs_pkg;

  // one in signed q.48
  localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;

  // width of a factorial step divisor, enough for 62 * 63
  localparam int DIV_W = 12;

  // pipeline depths of the shared parts
  localparam int MUL_LAT  = 2;
  localparam int CDIV_LAT = 8;
  localparam int CELL_LAT = MUL_LAT + CDIV_LAT + 1;
  localparam int QBITS    = 47;
  localparam int TDIV_LAT = QBITS + 2;

  // saturation limits of a q16.32 word
  localparam logic [47:0] VAL_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] VAL_MIN = 48'h8000_0000_0000;

endpackage

`default_nettype wire

/* rtl/core/scs_mul.sv */
`default_nettype none

// unsigned a * b / 2^48, rounded to nearest, two stages
module scs_mul (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0]  pp00;
  logic [63:0]  pp01;
  logic [63:0]  pp10;
  logic [63:0]  pp11;
  logic [127:0] sum;

  always_ff @(posedge clk) begin
    pp00 <= 64'(a[31:0]) * 64'(b[31:0]);
    pp01 <= 64'(a[31:0]) * 64'(b[63:32]);
    pp10 <= 64'(a[63:32]) * 64'(b[31:0]);
    pp11 <= 64'(a[63:32]) * 64'(b[63:32]);
  end

  assign sum = {64'b0, pp00} + {32'b0, pp01, 32'b0} + {32'b0, pp10, 32'b0}
             + {pp11, 64'b0} + 128'h8000_0000_0000;

  always_ff @(posedge clk) begin
    p <= sum[111:48];
  end

endmodule

`default_nettype wire

/* rtl/core/scs_cdiv.sv */
`default_nettype none

// floor(x / DIVISOR), one byte of quotient per stage
module scs_cdiv #(
  parameter int unsigned DIVISOR = 2
) (
  input  logic        clk,
  input  logic [63:0] x,
  output logic [63:0] q
);

  import scs_pkg::*;

  localparam logic [DIV_W+7:0] DIV_EXT = (DIV_W + 8)'(DIVISOR);

  function automatic logic [DIV_W+7:0] div_byte(input logic [DIV_W+7:0] t_in);
    logic [DIV_W+7:0] t;
    logic [7:0]       qb;
    t  = t_in;
    qb = '0;
    for (int b = 7; b >= 0; b--) begin
      if (t >= (DIV_EXT << b)) begin
        t     = t - (DIV_EXT << b);
        qb[b] = 1'b1;
      end
    end
    return {t[DIV_W-1:0], qb};
  endfunction

  logic [DIV_W-1:0] rem [1:CDIV_LAT-1];
  logic [63:0]      num [1:CDIV_LAT-1];
  logic [63:0]      quo [1:CDIV_LAT];

  for (genvar g = 0; g < CDIV_LAT; g++) begin : g_stage
    logic [DIV_W-1:0] r_in;
    logic [63:0]      n_in;
    logic [63:0]      q_in;
    logic [DIV_W+7:0] res;

    if (g == 0) begin : g_first
      assign r_in = '0;
      assign n_in = x;
      assign q_in = '0;
    end else begin : g_rest
      assign r_in = rem[g];
      assign n_in = num[g];
      assign q_in = quo[g];
    end

    assign res = div_byte({r_in, n_in[63:56]});

    always_ff @(posedge clk) begin
      quo[g+1] <= {q_in[55:0], res[7:0]};
    end

    if (g < CDIV_LAT - 1) begin : g_carry
      always_ff @(posedge clk) begin
        rem[g+1] <= res[DIV_W+7:8];
        num[g+1] <= {n_in[55:0], 8'b0};
      end
    end
  end

  assign q = quo[CDIV_LAT];

endmodule

`default_nettype wire

/* rtl/core/scs_cell.sv */
`default_nettype none

// one horner step for the sine and cosine series: acc = 1 - acc * r2 / d
module scs_cell #(
  parameter int unsigned K = 1
) (
  input  logic               clk,
  input  logic signed [63:0] acc_s_in,
  input  logic signed [63:0] acc_c_in,
  input  logic        [63:0] r2_in,
  output logic signed [63:0] acc_s_out,
  output logic signed [63:0] acc_c_out,
  output logic        [63:0] r2_out
);

  import scs_pkg::*;

  localparam int unsigned D_SIN = (2 * K) * (2 * K + 1);
  localparam int unsigned D_COS = (2 * K - 1) * (2 * K);

  logic signed [63:0] acc_in  [0:1];
  logic signed [63:0] acc_out [0:1];
  logic        [63:0] r2_d    [0:CELL_LAT-1];

  assign acc_in[0] = acc_s_in;
  assign acc_in[1] = acc_c_in;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam int unsigned D = (l == 0) ? D_SIN : D_COS;

    logic                neg;
    logic [63:0]         mag;
    logic [63:0]         prod;
    logic [63:0]         quot;
    logic [CELL_LAT-2:0] sign_d;

    assign neg = acc_in[l][63];
    assign mag = neg ? 64'(0) - 64'(acc_in[l]) : 64'(acc_in[l]);

    scs_mul u_mul (
      .clk (clk),
      .a   (mag),
      .b   (r2_in),
      .p   (prod)
    );

    scs_cdiv #(
      .DIVISOR (D)
    ) u_div (
      .clk (clk),
      .x   (prod),
      .q   (quot)
    );

    always_ff @(posedge clk) begin
      sign_d     <= {sign_d[CELL_LAT-3:0], neg};
      // magnitude form of the signed truncating divide
      acc_out[l] <= sign_d[CELL_LAT-2] ? signed'(ONE_Q48 + quot) : signed'(ONE_Q48 - quot);
    end
  end

  always_ff @(posedge clk) begin
    r2_d[0] <= r2_in;
    for (int i = 1; i < CELL_LAT; i++) begin
      r2_d[i] <= r2_d[i-1];
    end
  end

  assign acc_s_out = acc_out[0];
  assign acc_c_out = acc_out[1];
  assign r2_out    = r2_d[CELL_LAT-1];

endmodule

`default_nettype wire

/* rtl/core/scs_tdiv.sv */
`default_nettype none

// tangent quotient s / c in q16.32, truncated, with saturation
module scs_tdiv (
  input  logic               clk,
  input  logic signed [63:0] s,
  input  logic signed [63:0] c,
  output logic        [47:0] value,
  output logic               err
);

  import scs_pkg::*;

  typedef struct packed {
    logic qneg;
    logic zero;
    logic ovf;
    logic sneg;
  } tdiv_ctl_t;

  logic [63:0]      sm;
  logic [63:0]      cm_d [0:QBITS-1];
  tdiv_ctl_t        ctl  [0:QBITS];
  logic [95:0]      n    [1:QBITS-1];
  logic [QBITS-1:0] qv   [1:QBITS];
  logic [63:0]      s_mag;
  logic [63:0]      c_mag;
  logic [QBITS:0]   q_ext;

  assign s_mag = s[63] ? 64'(0) - 64'(s) : 64'(s);
  assign c_mag = c[63] ? 64'(0) - 64'(c) : 64'(c);

  always_ff @(posedge clk) begin
    sm          <= s_mag;
    cm_d[0]     <= c_mag;
    ctl[0].qneg <= s[63] ^ c[63];
    ctl[0].zero <= (c == '0);
    ctl[0].ovf  <= 80'(s_mag) >= (80'(c_mag) << 15);
    ctl[0].sneg <= s[63];
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar g = 0; g < QBITS; g++) begin : g_step
    localparam int SH = QBITS - 1 - g;

    logic [95:0]      n_in;
    logic [QBITS-1:0] q_in;
    logic [111:0]     sub;
    logic             ge;

    if (g == 0) begin : g_first
      assign n_in = {sm, 32'b0};
      assign q_in = '0;
    end else begin : g_rest
      assign n_in = n[g];
      assign q_in = qv[g];
    end

    assign sub = 112'(cm_d[g]) << SH;
    assign ge  = 112'(n_in) >= sub;

    always_ff @(posedge clk) begin
      qv[g+1]  <= {q_in[QBITS-2:0], ge};
      ctl[g+1] <= ctl[g];
    end

    if (g < QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        n[g+1]    <= ge ? n_in - sub[95:0] : n_in;
        cm_d[g+1] <= cm_d[g];
      end
    end
  end

  assign q_ext = {1'b0, qv[QBITS]};

  always_ff @(posedge clk) begin
    priority if (ctl[QBITS].zero) begin
      err   <= 1'b1;
      value <= ctl[QBITS].sneg ? VAL_MIN : VAL_MAX;
    end else if (ctl[QBITS].ovf) begin
      err   <= 1'b1;
      value <= ctl[QBITS].qneg ? VAL_MIN : VAL_MAX;
    end else begin
      err   <= 1'b0;
      value <= ctl[QBITS].qneg ? 48'(0) - q_ext : q_ext;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/sine_cosine_tangent_series.sv */
// throughput: one word per cycle; busy is always low, every stage is a register
// the depth is set by the chain of horner cells and the one-bit-per-stage
// tangent divider; the receiver cannot stall, done lasts one cycle
// reset (rst, synchronous, active high) clears only the valid bits of the pipeline
`default_nettype none

module sine_cosine_tangent_series #(
  parameter int TERMS = 29
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic        [1:0]  action,
  input  logic signed [31:0] angle,
  output logic        [47:0] value,
  output logic               domain_error,
  output logic               done
);

  import scs_pkg::*;

  // action codes
  localparam logic [1:0] ACT_SIN = 2'd0;
  localparam logic [1:0] ACT_COS = 2'd1;
  localparam logic [1:0] ACT_TAN = 2'd2;

  // two pi in unsigned q.56, rounded to nearest
  localparam logic [63:0] TWO_PI_Q56 = 64'h0648_7ED5_110B_4612;

  // the turn count is at most 20, so five restoring steps reduce the angle
  localparam int RED_STEPS = 5;
  localparam int NC        = TERMS - 1;
  localparam int LEN1      = MUL_LAT + NC * CELL_LAT;
  localparam int LAT       = 1 + RED_STEPS + 1 + MUL_LAT + NC * CELL_LAT + MUL_LAT + 1
                           + TDIV_LAT + 1;

  typedef struct packed {
    logic       valid;
    logic [1:0] action;
    logic       neg;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [50:0] r48;
  } carry1_t;

  typedef struct packed {
    side_t              side;
    logic               sser_neg;
    logic signed [63:0] c;
  } carry2_t;

  typedef struct packed {
    side_t       side;
    logic [47:0] val;
  } carry3_t;

  // signed q.48 to q16.32, rounded half away from zero
  function automatic logic [47:0] to_q32(input logic signed [63:0] v);
    logic [63:0] m;
    m = (v[63] ? 64'(0) - 64'(v) : 64'(v)) + 64'h8000;
    return v[63] ? 48'(0) - m[63:16] : m[63:16];
  endfunction

  // input register: angle magnitude and sign
  side_t       in_side;
  logic [31:0] in_am;
  logic [31:0] angle_u;

  // reduction by whole turns, restoring division by two pi
  side_t       red_side [0:RED_STEPS-1];
  logic [63:0] red_rem  [0:RED_STEPS-1];

  // reduced angle in q.48 and its square
  side_t       rnd_side;
  logic [50:0] r48;
  logic [63:0] rnd_sum;
  logic [63:0] r2;

  // chain of horner cells, index 0 is the head
  carry1_t            l1 [0:LEN1-1];
  logic signed [63:0] acc_s [0:NC];
  logic signed [63:0] acc_c [0:NC];
  logic        [63:0] r2_c  [0:NC];

  // sine times the reduced angle
  logic [63:0] sser_mag;
  logic [63:0] sprod;
  carry2_t     l2 [0:MUL_LAT-1];

  // sine and cosine in q.48, formatted result for sine and cosine words
  side_t              sc_side;
  logic signed [63:0] sc_s;
  logic signed [63:0] sc_c;
  logic        [47:0] sc_val;
  logic signed [63:0] s_next;
  logic        [47:0] val_next;

  // wait for the tangent divider
  carry3_t     l3 [0:TDIV_LAT-1];
  logic [47:0] tan_val;
  logic        tan_err;

  // no stage ever waits, so a word is taken every cycle
  assign busy    = 1'b0;
  assign angle_u = angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_side.valid <= 1'b0;
    end else begin
      in_side.valid <= start && !busy;
    end
    in_side.action <= action;
    in_side.neg    <= angle_u[31];
    in_am          <= angle_u[31] ? 32'(0) - angle_u : angle_u;
  end

  for (genvar g = 0; g < RED_STEPS; g++) begin : g_red
    localparam logic [63:0] TP = TWO_PI_Q56 << (RED_STEPS - 1 - g);

    side_t       s_in;
    logic [63:0] r_in;

    if (g == 0) begin : g_first
      assign s_in = in_side;
      assign r_in = {in_am, 32'b0};
    end else begin : g_rest
      assign s_in = red_side[g-1];
      assign r_in = red_rem[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        red_side[g].valid <= 1'b0;
      end else begin
        red_side[g].valid <= s_in.valid;
      end
      red_side[g].action <= s_in.action;
      red_side[g].neg    <= s_in.neg;
      red_rem[g]         <= (r_in >= TP) ? r_in - TP : r_in;
    end
  end

  // round q.56 to q.48; the remainder stays below 2^59
  assign rnd_sum = red_rem[RED_STEPS-1] + 64'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_side.valid <= 1'b0;
    end else begin
      rnd_side.valid <= red_side[RED_STEPS-1].valid;
    end
    rnd_side.action <= red_side[RED_STEPS-1].action;
    rnd_side.neg    <= red_side[RED_STEPS-1].neg;
    r48             <= rnd_sum[58:8];
  end

  scs_mul u_sq (
    .clk (clk),
    .a   (64'(r48)),
    .b   (64'(r48)),
    .p   (r2)
  );

  // side data and reduced angle ride along the square and the cells
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEN1; i++) begin
        l1[i].side.valid <= 1'b0;
      end
    end else begin
      l1[0].side.valid <= rnd_side.valid;
      for (int i = 1; i < LEN1; i++) begin
        l1[i].side.valid <= l1[i-1].side.valid;
      end
    end
    l1[0].side.action <= rnd_side.action;
    l1[0].side.neg    <= rnd_side.neg;
    l1[0].r48         <= r48;
    for (int i = 1; i < LEN1; i++) begin
      l1[i].side.action <= l1[i-1].side.action;
      l1[i].side.neg    <= l1[i-1].side.neg;
      l1[i].r48         <= l1[i-1].r48;
    end
  end

  // horner sums start at one; the head cell carries the highest term
  assign acc_s[0] = signed'(ONE_Q48);
  assign acc_c[0] = signed'(ONE_Q48);
  assign r2_c[0]  = r2;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    scs_cell #(
      .K (NC - g)
    ) u_cell (
      .clk       (clk),
      .acc_s_in  (acc_s[g]),
      .acc_c_in  (acc_c[g]),
      .r2_in     (r2_c[g]),
      .acc_s_out (acc_s[g+1]),
      .acc_c_out (acc_c[g+1]),
      .r2_out    (r2_c[g+1])
    );
  end

  // sin(r) = r * (sin(r) / r); the reduced angle is never negative
  assign sser_mag = acc_s[NC][63] ? 64'(0) - 64'(acc_s[NC]) : 64'(acc_s[NC]);

  scs_mul u_smul (
    .clk (clk),
    .a   (64'(l1[LEN1-1].r48)),
    .b   (sser_mag),
    .p   (sprod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        l2[i].side.valid <= 1'b0;
      end
    end else begin
      l2[0].side.valid <= l1[LEN1-1].side.valid;
      for (int i = 1; i < MUL_LAT; i++) begin
        l2[i].side.valid <= l2[i-1].side.valid;
      end
    end
    l2[0].side.action <= l1[LEN1-1].side.action;
    l2[0].side.neg    <= l1[LEN1-1].side.neg;
    l2[0].sser_neg    <= acc_s[NC][63];
    l2[0].c           <= acc_c[NC];
    for (int i = 1; i < MUL_LAT; i++) begin
      l2[i].side.action <= l2[i-1].side.action;
      l2[i].side.neg    <= l2[i-1].side.neg;
      l2[i].sser_neg    <= l2[i-1].sser_neg;
      l2[i].c           <= l2[i-1].c;
    end
  end

  // sine sign: series sign, flipped again for a negative angle
  assign s_next = (l2[MUL_LAT-1].sser_neg ^ l2[MUL_LAT-1].side.neg)
                ? signed'(64'(0) - sprod) : signed'(sprod);

  always_comb begin
    unique case (l2[MUL_LAT-1].side.action)
      ACT_SIN: val_next = to_q32(s_next);
      ACT_COS: val_next = to_q32(l2[MUL_LAT-1].c);
      default: val_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc_side.valid <= 1'b0;
    end else begin
      sc_side.valid <= l2[MUL_LAT-1].side.valid;
    end
    sc_side.action <= l2[MUL_LAT-1].side.action;
    sc_side.neg    <= l2[MUL_LAT-1].side.neg;
    sc_s           <= s_next;
    sc_c           <= l2[MUL_LAT-1].c;
    sc_val         <= val_next;
  end

  scs_tdiv u_tdiv (
    .clk   (clk),
    .s     (sc_s),
    .c     (sc_c),
    .value (tan_val),
    .err   (tan_err)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TDIV_LAT; i++) begin
        l3[i].side.valid <= 1'b0;
      end
    end else begin
      l3[0].side.valid <= sc_side.valid;
      for (int i = 1; i < TDIV_LAT; i++) begin
        l3[i].side.valid <= l3[i-1].side.valid;
      end
    end
    l3[0].side.action <= sc_side.action;
    l3[0].side.neg    <= sc_side.neg;
    l3[0].val         <= sc_val;
    for (int i = 1; i < TDIV_LAT; i++) begin
      l3[i].side.action <= l3[i-1].side.action;
      l3[i].side.neg    <= l3[i-1].side.neg;
      l3[i].val         <= l3[i-1].val;
    end
  end

  // output register: tangent from the divider, anything else from the delay line
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= l3[TDIV_LAT-1].side.valid;
    end
    if (l3[TDIV_LAT-1].side.action == ACT_TAN) begin
      value        <= tan_val;
      domain_error <= tan_err;
    end else begin
      value        <= l3[TDIV_LAT-1].val;
      domain_error <= 1'b0;
    end
  end

`ifndef ASSERT_OFF
  a_fixed_latency : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("accepted word did not come out after the pipeline depth");

  a_no_stray_done : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("done without a matching accepted word");

  a_err_tan_only : assert property (@(posedge clk) disable iff (rst)
    (l3[TDIV_LAT-1].side.valid && l3[TDIV_LAT-1].side.action != ACT_TAN)
      |=> !domain_error)
    else $error("domain_error raised for sine, cosine or unused code");
`endif

endmodule

`default_nettype wire

/* tb/sine_cosine_tangent_series_tb.sv */
`timescale 1ns / 1ps

module sine_cosine_tangent_series_tb;
  import scs_pkg::*;

  localparam int N_TERMS    = 29;
  localparam int N_RANDOM   = 1600;
  localparam int WATCH_LIM  = 6000;
  localparam int TAIL_WAIT  = 450;

  // action codes
  typedef enum logic [1:0] {
    ACT_SIN = 2'd0,
    ACT_COS = 2'd1,
    ACT_TAN = 2'd2,
    ACT_NONE = 2'd3
  } act_e;

  localparam logic [63:0] TWO_PI_Q56 = 64'h0648_7ED5_110B_4612;
  localparam longint ONE48 = 64'sh0001_0000_0000_0000;
  localparam logic [47:0] VMASK = 48'hFFFF_FFFF_FFFF;
  // pi/2 and two pi in q8.24
  localparam int HALF_PI_Q24 = 26353589;
  localparam int TWO_PI_Q24  = 105414357;

  typedef struct {
    act_e              action;
    logic signed [31:0] angle;
    bit                drain;
  } angle_word_t;

  typedef struct {
    logic [47:0] value;
    logic        domain_error;
  } trig_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] action = 2'd0;
  logic signed [31:0] angle = 32'sd0;
  logic [47:0] value;
  logic domain_error;
  logic done;

  angle_word_t pending_angles[$];
  trig_word_t  expected_trig[$];

  int sent_cnt = 0;
  int recv_cnt = 0;
  int err_cnt = 0;
  int derr_cnt = 0;
  int act_cnt[4] = '{0, 0, 0, 0};
  int gap_cnt = 0;
  int watch_cnt = 0;

  sine_cosine_tangent_series #(.TERMS(N_TERMS)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .angle(angle),
    .value(value),
    .domain_error(domain_error),
    .done(done)
  );

  always #5 clk = ~clk;

  // magnitude of a signed 64-bit value as unsigned
  function automatic logic [63:0] mag64(input longint v);
    return v < 0 ? 64'd0 - 64'(v) : 64'(v);
  endfunction

  // signed q.48 product, rounded to nearest on magnitudes
  function automatic longint qmul(input longint a, input longint b);
    logic [127:0] p;
    longint m;
    p = {64'd0, mag64(a)} * {64'd0, mag64(b)} + (128'd1 << 47);
    m = longint'(p[111:48]);
    return ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  // horner sum: odd gives sin(r)/r, else cos(r)
  function automatic longint horner(input longint r2, input bit odd);
    longint acc;
    longint d;
    acc = ONE48;
    for (int k = N_TERMS - 1; k >= 1; k--) begin
      d = odd ? longint'(2 * k) * (2 * k + 1) : longint'(2 * k - 1) * (2 * k);
      acc = ONE48 - qmul(acc, r2) / d;
    end
    return acc;
  endfunction

  // q.48 to q16.32, round half away from zero
  function automatic logic [47:0] to_q32(input longint v);
    logic [63:0] m;
    m = (mag64(v) + 64'd32768) >> 16;
    return 48'(v < 0 ? (64'd0 - m) : m);
  endfunction

  // expected word for one angle and selector
  function automatic trig_word_t eval_trig(input act_e act, input logic signed [31:0] ang);
    trig_word_t w;
    logic [63:0] raw, am, big, q, r56, sm, cm, ip, rem, frac, m;
    bit neg, qneg;
    longint r48, r2, s, c;
    w.value = '0;
    w.domain_error = 1'b0;
    raw = {32'd0, ang};
    neg = ang[31];
    am = neg ? (64'd1 << 32) - raw : raw;
    big = am << 32;
    q = big / TWO_PI_Q56;
    r56 = big - q * TWO_PI_Q56;
    r48 = longint'((r56 + 64'd128) >> 8);
    r2 = qmul(r48, r48);
    s = qmul(r48, horner(r2, 1'b1));
    c = horner(r2, 1'b0);
    if (neg) s = -s;
    case (act)
      ACT_SIN: w.value = to_q32(s);
      ACT_COS: w.value = to_q32(c);
      ACT_TAN: begin
        qneg = (s < 0) != (c < 0);
        if (c == 0) begin
          // zero cosine saturates on the sign of the sine
          w.domain_error = 1'b1;
          w.value = s < 0 ? VAL_MIN : VAL_MAX;
        end else begin
          sm = mag64(s);
          cm = mag64(c);
          ip = sm / cm;
          rem = sm - ip * cm;
          if (ip >= (64'd1 << 15)) begin
            // quotient out of q16.32 range
            w.domain_error = 1'b1;
            w.value = qneg ? VAL_MIN : VAL_MAX;
          end else begin
            frac = 0;
            for (int i = 0; i < 32; i++) begin
              rem = rem << 1;
              frac = frac << 1;
              if (rem >= cm) begin
                rem = rem - cm;
                frac[0] = 1'b1;
              end
            end
            m = (ip << 32) | frac;
            w.value = 48'(qneg ? 64'd0 - m : m);
          end
        end
      end
      default: w.value = '0;
    endcase
    w.value = w.value & VMASK;
    return w;
  endfunction

  function automatic void add_word(input act_e a, input logic signed [31:0] g, input bit dr);
    angle_word_t w;
    w.action = a;
    w.angle = g;
    w.drain = dr;
    pending_angles.push_back(w);
  endfunction

  // stimulus: directed corners then a random mix
  initial begin
    int sel;
    int base;
    act_e a;
    logic signed [31:0] g;
    // extremes and zero of the angle for each selector
    for (int i = 0; i < 4; i++) begin
      add_word(act_e'(i), 32'sh7FFF_FFFF, 1'b0);
      add_word(act_e'(i), 32'sh8000_0000, 1'b0);
      add_word(act_e'(i), 32'sd0, 1'b0);
    end
    add_word(ACT_SIN, 32'sd1, 1'b0);
    add_word(ACT_COS, -32'sd1, 1'b0);
    add_word(ACT_SIN, TWO_PI_Q24, 1'b0);
    add_word(ACT_COS, -TWO_PI_Q24, 1'b0);
    // tangent near the cosine zero: overflow and sign flips
    add_word(ACT_TAN, HALF_PI_Q24, 1'b0);
    add_word(ACT_TAN, HALF_PI_Q24 + 1, 1'b0);
    add_word(ACT_TAN, HALF_PI_Q24 - 1, 1'b0);
    add_word(ACT_TAN, -HALF_PI_Q24, 1'b0);
    add_word(ACT_TAN, 3 * HALF_PI_Q24, 1'b0);
    add_word(ACT_TAN, 32'sh0100_0000, 1'b0);
    add_word(ACT_NONE, 32'sh1234_5678, 1'b0);
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(99);
      a = (sel < 5) ? ACT_NONE : act_e'($urandom_range(2));
      case ($urandom_range(3))
        0: g = $urandom;
        1: g = $urandom_range(2 * TWO_PI_Q24) - TWO_PI_Q24;
        2: begin
          // close to an odd multiple of pi/2, where the tangent blows up
          base = (2 * $urandom_range(20) + 1) * HALF_PI_Q24;
          g = base + $urandom_range(200) - 100;
          if ($urandom_range(1)) g = -g;
          if (sel < 60) a = ACT_TAN;
        end
        default: g = $urandom_range(4096) - 2048;
      endcase
      // wait for the pipeline to empty a couple of times
      add_word(a, g, (n == 500 || n == 1100));
    end
  end

  // driver
  always @(posedge clk) begin
    bit free;
    bit go;
    angle_word_t w;
    int blk;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) begin
        expected_trig.push_back(eval_trig(act_e'(action), angle));
        act_cnt[action]++;
        sent_cnt++;
      end
      free = !start || !busy;
      if (free) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
        end else if (pending_angles.size() > 0) begin
          if (!(pending_angles[0].drain && expected_trig.size() > 0)) go = 1'b1;
        end
      end
      if (go) begin
        w = pending_angles.pop_front();
        action <= w.action;
        angle <= w.angle;
        start <= 1'b1;
        // stretches of back-to-back words between random gaps
        blk = (sent_cnt / 200) % 3;
        gap_cnt = (blk == 0) ? 0 : $urandom_range(8);
      end else if (free) begin
        start <= 1'b0;
      end
    end
  end

  // monitor: done lasts one cycle, compare with the oldest prediction
  always @(posedge clk) begin
    trig_word_t e;
    if (!rst && done) begin
      recv_cnt++;
      if (domain_error) derr_cnt++;
      if (expected_trig.size() == 0) begin
        $error("unexpected word: value %h domain_error %b", value, domain_error);
        err_cnt++;
      end else begin
        e = expected_trig.pop_front();
        if (value !== e.value) begin
          $error("value: expected %h actual %h", e.value, value);
          err_cnt++;
        end
        if (domain_error !== e.domain_error) begin
          $error("domain_error: expected %b actual %b", e.domain_error, domain_error);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      watch_cnt <= 0;
    end else if (watch_cnt >= WATCH_LIM) begin
      $display("Mismatches found");
      $finish;
    end else begin
      watch_cnt <= watch_cnt + 1;
    end
  end

  // reset, then wait for everything to drain
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (pending_angles.size() != 0 || start) @(posedge clk);
    while (expected_trig.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (expected_trig.size() != 0) begin
      $error("%0d predicted words never arrived", expected_trig.size());
      err_cnt++;
    end
    $display("run covered %0d words: sin %0d, cos %0d, tan %0d, unused %0d",
             sent_cnt, act_cnt[0], act_cnt[1], act_cnt[2], act_cnt[3]);
    $display("%0d results checked, %0d with domain_error set", recv_cnt, derr_cnt);
    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/scs_pkg.sv
rtl/core/scs_mul.sv
rtl/core/scs_cdiv.sv
rtl/core/scs_cell.sv
rtl/core/scs_tdiv.sv
rtl/core/sine_cosine_tangent_series.sv
tb/sine_cosine_tangent_series_tb.sv
